/* rtl/core/deq_pkg.sv */
// shared types and codes for the double-ended queue
package deq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  // operation codes
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd1;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_LIST       = 3'd4;

  // result status codes
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_UNDER  = 3'd1;
  localparam logic [2:0] ST_OVER   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_LISTED = 3'd4;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] item;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             push_front;
    logic             pop_front;
    logic             push_back;
    logic             rotate;
    logic [CNT_W-1:0] count;
  } deq_ctl_t;

endpackage

/* rtl/core/deq_cell.sv */
// one storage cell of the queue chain
module deq_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  deq_pkg::deq_ctl_t                ctl,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  input  logic signed [deq_pkg::DATA_W-1:0] left_val,
  input  logic signed [deq_pkg::DATA_W-1:0] right_val,
  input  logic signed [deq_pkg::DATA_W-1:0] head_val,
  output logic signed [deq_pkg::DATA_W-1:0] val,
  output logic signed [deq_pkg::DATA_W-1:0] tail_val
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;
  logic [CNT_W-1:0]         last_pos;

  assign last_pos = ctl.count - 1'b1;

  always_comb begin
    val_nxt = val_r;
    if (ctl.push_front) begin
      val_nxt = (IDX == 0) ? in_value : left_val;
    end else if (ctl.pop_front) begin
      val_nxt = right_val;
    end else if (ctl.push_back) begin
      if (IDX_C == ctl.count) begin
        val_nxt = in_value;
      end
    end else if (ctl.rotate) begin
      // front entry wraps around to the back of the held range
      if (IDX_C == last_pos) begin
        val_nxt = head_val;
      end else if (IDX_C < last_pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign tail_val = (IDX_C == last_pos && ctl.count != '0) ? val_r : '0;

endmodule

/* rtl/core/double_ended_queue.sv */
// top level of the double-ended queue built from a chain of cells
// The queue holds up to DEPTH signed 32-bit values in a row of cells with the front
// entry always in cell 0. Push front, pop front, push back and pop back each give one
// result transaction; a new one is taken every cycle while the output register drains.
// A list of an empty queue gives a single empty report. A list of a nonempty queue
// first takes the transaction, then the chain rotates by one cell per cycle while the
// output is not held, presenting the front entry each time and returning to its original
// order when done; input is stalled during the list and whenever the output is held.
// Pushing onto a full queue reports overflow; popping or listing an empty one reports
// underflow or empty. Kind codes 5 to 7 are consumed without any result.
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  deq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output deq_pkg::out_t out_data
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                     state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         list_idx_r, list_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_data_r, out_data_nxt;

  deq_ctl_t                 ctl;
  logic signed [DATA_W-1:0] cell_val  [DEPTH];
  logic signed [DATA_W-1:0] cell_tail [DEPTH];
  logic signed [DATA_W-1:0] tail_val;
  logic                     out_free;
  logic                     in_accept;
  logic                     full;
  logic                     empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      deq_cell #(.IDX(g)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .in_value  (in_data.value),
        .left_val  (cell_val[(g == 0) ? 0 : g - 1]),
        .right_val (cell_val[(g == DEPTH - 1) ? g : g + 1]),
        .head_val  (cell_val[0]),
        .val       (cell_val[g]),
        .tail_val  (cell_tail[g])
      );
    end
  endgenerate

  // only the back cell drives a nonzero tail value
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | cell_tail[i];
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == DEPTH_C);
  assign empty     = (count_r == '0);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    list_idx_nxt   = list_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ctl            = '0;
    ctl.count      = count_r;

    if (in_accept) begin
      case (in_data.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          out_valid_nxt = 1'b1;
          out_data_nxt.last = 1'b1;
          if (full) begin
            out_data_nxt.status = ST_OVER;
            out_data_nxt.item   = '0;
            out_data_nxt.count  = count_r;
          end else begin
            ctl.push_front      = (in_data.kind == KIND_PUSH_FRONT);
            ctl.push_back       = (in_data.kind == KIND_PUSH_BACK);
            count_nxt           = count_r + 1'b1;
            out_data_nxt.status = ST_DONE;
            out_data_nxt.item   = in_data.value;
            out_data_nxt.count  = count_r + 1'b1;
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          out_valid_nxt = 1'b1;
          out_data_nxt.last = 1'b1;
          if (empty) begin
            out_data_nxt.status = ST_UNDER;
            out_data_nxt.item   = '0;
            out_data_nxt.count  = '0;
          end else begin
            ctl.pop_front       = (in_data.kind == KIND_POP_FRONT);
            count_nxt           = count_r - 1'b1;
            out_data_nxt.status = ST_DONE;
            out_data_nxt.item   = (in_data.kind == KIND_POP_FRONT) ? cell_val[0] : tail_val;
            out_data_nxt.count  = count_r - 1'b1;
          end
        end
        KIND_LIST: begin
          if (empty) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_EMPTY;
            out_data_nxt.item   = '0;
            out_data_nxt.count  = '0;
            out_data_nxt.last   = 1'b1;
          end else begin
            state_nxt    = S_LIST;
            list_idx_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == S_LIST && out_free) begin
      ctl.rotate          = 1'b1;
      out_valid_nxt       = 1'b1;
      out_data_nxt.status = ST_LISTED;
      out_data_nxt.item   = cell_val[0];
      out_data_nxt.count  = count_r;
      out_data_nxt.last   = (list_idx_r == count_r - 1'b1);
      list_idx_nxt        = list_idx_r + 1'b1;
      if (list_idx_r == count_r - 1'b1) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/deq_checker.sv */
// port-level checks for the double-ended queue, bound to the top level
module deq_checker #(
  parameter int DEPTH = 64
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input deq_pkg::out_t out_data
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // a held result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // never more entries than the ring holds
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count <= DEPTH_C)
    else $error("result count exceeds depth");

  // underflow and empty reports carry no item and a zero count and end the transaction
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_UNDER || out_data.status == ST_EMPTY)
      |-> out_data.count == '0 && out_data.item == '0 && out_data.last)
    else $error("underflow or empty report malformed");

  // overflow only on a full queue
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OVER |-> out_data.count == DEPTH_C)
    else $error("overflow reported on a queue that is not full");

  // no new transaction is taken while a list is still being sent
  a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken in the middle of a list");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
